// ===== rtl/aes_pkg.sv =====
// AES-128 shared package: S-box, GF(2^8) helpers, round step functions.
// Used by every module of the block; no dependencies.
`default_nettype none
package aes_pkg;

    localparam int unsigned ROUNDS     = 10;
    localparam int unsigned DATA_W     = 128;
    localparam int unsigned HALF_W     = 64;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef logic [DATA_W-1:0] block_t;

    typedef struct packed {
        logic   valid;
        block_t data;
    } stage_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] lut [256];
        lut = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return lut[x];
    endfunction

    // Round constant for round r (1..10)
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte n of a block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input block_t s, input int n);
        return s[DATA_W-1-8*n -: 8];
    endfunction

    // SubBytes plus ShiftRows
    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[DATA_W-1-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)%4)+r));
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            al = a0 ^ a1 ^ a2 ^ a3;
            t[DATA_W-1-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[DATA_W-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[DATA_W-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[DATA_W-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    // Next round key from the previous one
    function automatic block_t next_key(input block_t k, input logic [3:0] r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])}
             ^ {rcon(r), 24'h0};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/aes128_block_encrypt.sv =====
// Top level of the AES-128 ECB encryptor: key registers, key schedule row,
// round cell row. Depends on aes_pkg, aes_key_cell, aes_round_cell.
//
//  channel | ports                          | handshake
//  input   | s_plain_high, s_plain_low      | s_valid / s_ready
//  output  | m_cipher_high, m_cipher_low    | m_valid / m_ready
//  config  | cfg_we, cfg_index, cfg_data    | write at cfg_we
//
// One block enters every cycle while the row is not stalled; the pipe is the initial
// AddRoundKey register plus ten round cells. The whole row shifts together and holds
// while the last cell's result is not taken. The key cells recompute every cycle,
// so each round key settles down the chain of key cells after a key write, just in time for
// a block that enters the cycle after the write. Reset clears all valid bits
// and the key to zero; the schedule follows the same wavefront.
`default_nettype none
module aes128_block_encrypt (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [63:0] s_plain_high,
    input  wire  [63:0] s_plain_low,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [63:0] m_cipher_high,
    output logic [63:0] m_cipher_low,
    input  wire         cfg_we,
    input  wire  [0:0]  cfg_index,
    input  wire  [63:0] cfg_data
);
    localparam int unsigned NR = aes_pkg::ROUNDS;

    aes_pkg::block_t key_reg;
    aes_pkg::stage_t st0_reg;
    aes_pkg::block_t rk [NR+1];
    aes_pkg::stage_t st [NR+1];
    logic            advance;

    // Hold the cipher key
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    aes_pkg::REG_KEY_HIGH: key_reg[127:64] <= cfg_data;
                    aes_pkg::REG_KEY_LOW:  key_reg[63:0]   <= cfg_data;
                    default:               key_reg         <= key_reg;
                endcase
            end
        end
    end

    assign rk[0]   = key_reg;
    assign advance = !st[NR].valid || m_ready;
    assign s_ready = advance;

    // Initial AddRoundKey stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_reg.valid <= 1'b0;
        end else if (advance) begin
            st0_reg.valid <= s_valid;
        end
        if (advance) begin
            st0_reg.data <= {s_plain_high, s_plain_low} ^ rk[0];
        end
    end

    assign st[0] = st0_reg;

    for (genvar r = 1; r <= NR; r++) begin : g_row
        aes_key_cell #(.RND(4'(r))) u_key (
            .aclk    (aclk),
            .key_in  (rk[r-1]),
            .key_out (rk[r])
        );
        aes_round_cell #(.FINAL(r == NR)) u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .stage_in  (st[r-1]),
            .stage_key (rk[r]),
            .stage_out (st[r])
        );
    end

    assign m_valid       = st[NR].valid;
    assign m_cipher_high = st[NR].data[127:64];
    assign m_cipher_low  = st[NR].data[63:0];

    // Valid and the upper cipher half must hold while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cipher_high))
        else $error("stalled result changed");
    // Input is taken only when the row can move
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready does not follow output stall");
    // A stall keeps the first stage's valid bit frozen
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st[0].valid))
        else $error("first stage moved under stall");
endmodule
`default_nettype wire

// ===== rtl/aes_key_cell.sv =====
// One key-schedule cell: registers round key r from round key r-1.
// Depends on aes_pkg.
`default_nettype none
module aes_key_cell #(
    parameter logic [3:0] RND = 4'd1
) (
    input  wire              aclk,
    input  aes_pkg::block_t  key_in,
    output aes_pkg::block_t  key_out
);
    aes_pkg::block_t key_reg;

    // Advance the schedule by one round every cycle
    always_ff @(posedge aclk) begin
        key_reg <= aes_pkg::next_key(key_in, RND);
    end

    assign key_out = key_reg;
endmodule
`default_nettype wire

// ===== rtl/aes_round_cell.sv =====
// One round cell: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Depends on aes_pkg.
`default_nettype none
module aes_round_cell #(
    parameter bit FINAL = 1'b0
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              advance,
    input  aes_pkg::stage_t  stage_in,
    input  aes_pkg::block_t  stage_key,
    output aes_pkg::stage_t  stage_out
);
    aes_pkg::stage_t stage_reg;
    aes_pkg::block_t mixed;

    // Round transform
    always_comb begin
        if (FINAL) begin
            mixed = aes_pkg::sub_shift(stage_in.data);
        end else begin
            mixed = aes_pkg::mix_columns(aes_pkg::sub_shift(stage_in.data));
        end
    end

    // Advance when the row moves; hold otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg.valid <= stage_in.valid;
        end
        if (advance) begin
            stage_reg.data <= mixed ^ stage_key;
        end
    end

    assign stage_out = stage_reg;
endmodule
`default_nettype wire

// ===== bench/aes_checker.sv =====
// Checker for the AES-128 ECB encryptor: predicts ciphertext per plaintext transfer
// and compares each result transfer. Depends on aes_pkg for widths and register indexes.
`timescale 1ns / 100ps
module aes_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire  [63:0] s_plain_high,
    input  wire  [63:0] s_plain_low,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire  [63:0] m_cipher_high,
    input  wire  [63:0] m_cipher_low,
    input  wire         cfg_we,
    input  wire  [0:0]  cfg_index,
    input  wire  [63:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);
    localparam logic [7:0] SBOX_TAB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    localparam logic [7:0] RCON_TAB [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                            8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    logic [63:0]     key_hi_q, key_lo_q;
    logic [31:0]     sched [44];
    aes_pkg::block_t cipher_q [$];

    function automatic logic [7:0] gmul2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Build the 44-word schedule from the held key
    task automatic rebuild_schedule();
        logic [31:0] t;
        sched[0] = key_hi_q[63:32];
        sched[1] = key_hi_q[31:0];
        sched[2] = key_lo_q[63:32];
        sched[3] = key_lo_q[31:0];
        for (int i = 4; i < 44; i++) begin
            t = sched[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {SBOX_TAB[t[31:24]], SBOX_TAB[t[23:16]], SBOX_TAB[t[15:8]],
                     SBOX_TAB[t[7:0]]} ^ {RCON_TAB[i/4-1], 24'h0};
            end
            sched[i] = sched[i-4] ^ t;
        end
    endtask

    function automatic aes_pkg::block_t encrypt_block(input logic [63:0] hi,
                                                      input logic [63:0] lo);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [31:0] w;
        aes_pkg::block_t out;
        for (int i = 0; i < 8; i++) begin
            s[i]   = hi[63-8*i -: 8];
            s[8+i] = lo[63-8*i -: 8];
        end
        for (int r = 0; r <= 10; r++) begin
            if (r > 0) begin
                // substitute and shift rows
                for (int c = 0; c < 4; c++)
                    for (int q = 0; q < 4; q++)
                        t[4*c+q] = SBOX_TAB[s[4*((c+q)%4)+q]];
                s = t;
                if (r < 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
                        s[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
                        s[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
                        s[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++) begin
                w = sched[4*r+c];
                s[4*c]   ^= w[31:24];
                s[4*c+1] ^= w[23:16];
                s[4*c+2] ^= w[15:8];
                s[4*c+3] ^= w[7:0];
            end
        end
        for (int i = 0; i < 16; i++) out[127-8*i -: 8] = s[i];
        return out;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending_count = 0;
        key_hi_q = '0;
        key_lo_q = '0;
        rebuild_schedule();
    end

    // Track key writes, predict on input transfers, compare on output transfers
    always @(posedge aclk) begin
        aes_pkg::block_t want;
        if (!aresetn) begin
            key_hi_q = '0;
            key_lo_q = '0;
            rebuild_schedule();
            cipher_q.delete();
        end else begin
            if (s_valid && s_ready)
                cipher_q.push_back(encrypt_block(s_plain_high, s_plain_low));
            if (m_valid && m_ready) begin
                if (cipher_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h %h",
                                              m_cipher_high, m_cipher_low));
                end else begin
                    want = cipher_q.pop_front();
                    if (m_cipher_high !== want[127:64])
                        report_mismatch($sformatf("cipher_high: got %h want %h",
                                                  m_cipher_high, want[127:64]));
                    if (m_cipher_low !== want[63:0])
                        report_mismatch($sformatf("cipher_low: got %h want %h",
                                                  m_cipher_low, want[63:0]));
                end
            end
            if (cfg_we) begin
                if (cfg_index == aes_pkg::REG_KEY_HIGH) key_hi_q = cfg_data;
                else if (cfg_index == aes_pkg::REG_KEY_LOW) key_lo_q = cfg_data;
                rebuild_schedule();
            end
        end
        pending_count = cipher_q.size();
    end
endmodule

// ===== bench/tb_top.sv =====
// Top of the AES-128 encryptor bench: clock, reset, key writes, plaintext and
// back-pressure stimulus, verdict. Depends on aes_pkg, aes_checker and the block.
`timescale 1ns / 100ps
module tb_top;
    localparam int PIPE_DEPTH  = 11;
    localparam int STALL_LIMIT = 5000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    wire         s_ready;
    logic [63:0] s_plain_high, s_plain_low;
    wire         m_valid;
    logic        m_ready;
    wire  [63:0] m_cipher_high, m_cipher_low;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count, pending_count;
    bit          calm_mode;
    int          quiet_cycles;

    aes128_block_encrypt uut (.*);
    aes_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_pattern();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            3: return ~(64'h1 << $urandom_range(0, 63));
            default: return rand64();
        endcase
    endfunction

    // Drive one plaintext and hold it until the transfer
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        while (!calm_mode && $urandom_range(0, 99) < 19) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_plain_high <= hi;
        s_plain_low  <= lo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait for the pipe to empty before touching the key
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (PIPE_DEPTH + 2) @(negedge aclk);
    endtask

    // Random back-pressure on the result side
    always @(negedge aclk) begin
        if (aresetn)
            m_ready <= calm_mode || ($urandom_range(0, 99) >= 19);
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("aes128_block_encrypt verification failed");
            $finish;
        end
    end

    initial begin
        logic [63:0] keys [6];
        s_valid = 1'b0; s_plain_high = '0; s_plain_low = '0;
        m_ready = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        calm_mode = 1'b0; quiet_cycles = 0;
        aresetn = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Zero key from reset, extreme plaintexts
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();
        // FIPS-197 example key, then one register alone changed
        write_key(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
        write_key(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block('0, '1);
        drain();
        write_key(aes_pkg::REG_KEY_LOW, '1);
        send_block('1, '0);
        drain();
        write_key(aes_pkg::REG_KEY_HIGH, '1);
        for (int i = 0; i < 8; i++) send_block(pick_pattern(), pick_pattern());
        drain();

        // Random phases over a spread of keys, extremes included
        keys = '{64'h0, 64'hffffffffffffffff, 64'h8000000000000001, rand64(), rand64(),
                 64'h0123456789abcdef};
        for (int ph = 0; ph < 6; ph++) begin
            write_key(aes_pkg::REG_KEY_HIGH, keys[ph]);
            write_key(aes_pkg::REG_KEY_LOW, keys[(ph + 3) % 6] ^ rand64() & {64{ph[0]}});
            for (int n = 0; n < 315; n++) begin
                calm_mode = (ph == 2);
                send_block(pick_pattern(), pick_pattern());
            end
            calm_mode = 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("aes128_block_encrypt verification clean");
        else
            $display("aes128_block_encrypt verification failed");
        $finish;
    end
endmodule
